// ===== rtl/setu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// setu_pkg
// Shared types and constants of the elimination tree unit.
// ----------------------------------------------------------------------------
package setu_pkg;

    localparam int MAX_ORDER = 1024;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int NODE_W    = IDX_W + 1;
    localparam int CQ_DEPTH  = 4;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);

    localparam logic [NODE_W-1:0] COL_NONE = '1;

    localparam logic CFG_SIZE = 1'b0;
    localparam logic CFG_PERM = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_ROW   = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CMD_ERR,
        CMD_LOAD,
        CMD_START,
        CMD_ROW,
        CMD_READ
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0] n;
        logic              use_perm;
    } t_cfg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAP,
        BK_WREAD,
        BK_WCHK,
        BK_RDATA
    } t_back_state;

endpackage
`default_nettype wire

// ===== rtl/setu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// setu_front
// Accepts transactions, range checks them, tracks the current column and
// turns each one into a command for the back end.
// ----------------------------------------------------------------------------
module setu_front import setu_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_push,
    input  wire logic [1:0]       i_action,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic [IDX_W-1:0] i_row,
    input  wire logic             i_q_full,
    output t_cmd                  o_cmd,
    output logic                  o_cmd_push
);

    logic [NODE_W-1:0] r_col;
    logic [NODE_W-1:0] n_col;
    logic [NODE_W-1:0] col_next;
    logic              idx_ok;
    logic              row_ok;
    logic              accept;

    assign accept     = i_push && !i_q_full;
    assign o_cmd_push = accept;
    assign col_next   = r_col + NODE_W'(1);
    assign idx_ok     = {1'b0, i_index} < i_cfg.n;
    assign row_ok     = {1'b0, i_row} < i_cfg.n;

    always_comb begin
        o_cmd.op  = CMD_ERR;
        o_cmd.idx = i_index;
        o_cmd.row = i_row;
        o_cmd.col = r_col[IDX_W-1:0];
        n_col     = r_col;
        case (t_action'(i_action))
            ACT_LOAD: begin
                if (idx_ok && row_ok) begin
                    o_cmd.op = CMD_LOAD;
                end
            end
            ACT_START: begin
                if (r_col == COL_NONE) begin
                    n_col     = '0;
                    o_cmd.op  = CMD_START;
                    o_cmd.col = '0;
                end else if (col_next < i_cfg.n) begin
                    n_col     = col_next;
                    o_cmd.op  = CMD_START;
                    o_cmd.col = col_next[IDX_W-1:0];
                end
            end
            ACT_ROW: begin
                if (r_col != COL_NONE && row_ok) begin
                    o_cmd.op = CMD_ROW;
                end
            end
            ACT_READ: begin
                if (idx_ok) begin
                    o_cmd.op = CMD_READ;
                end
            end
            default: begin
                o_cmd.op = CMD_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= COL_NONE;
        end else if (accept) begin
            r_col <= n_col;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/setu_cmdq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// setu_cmdq
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module setu_cmdq import setu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd                r_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp;
    logic [CQ_PTR_W-1:0] r_rp;
    logic [CQ_PTR_W:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == (CQ_PTR_W+1)'(CQ_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + CQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + CQ_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (CQ_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (CQ_PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/setu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// setu_back
// Executes commands against the parent, mark and inverse permutation
// memories, walks parent chains and holds one finished result.
// ----------------------------------------------------------------------------
module setu_back import setu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire t_cmd              i_head,
    input  wire logic              i_q_empty,
    output logic                   o_q_pop,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [NODE_W-1:0]      o_parent_index,
    output logic                   o_error
);

    logic [NODE_W-1:0] r_par_mem  [MAX_ORDER];
    logic [IDX_W-1:0]  r_mark_mem [MAX_ORDER];
    logic [IDX_W-1:0]  r_inv_mem  [MAX_ORDER];

    logic [NODE_W-1:0] r_par_rdata;
    logic [IDX_W-1:0]  r_mark_rdata;
    logic [IDX_W-1:0]  r_inv_rdata;

    t_back_state       r_state, n_state;
    logic [NODE_W-1:0] r_i, n_i;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [NODE_W-1:0] r_steps, n_steps;
    logic              r_out_valid, n_out_valid;
    logic [NODE_W-1:0] r_out_parent, n_out_parent;
    logic              r_out_err, n_out_err;

    logic              take;
    logic              fin;
    logic [NODE_W-1:0] fin_parent;
    logic              fin_err;

    logic [IDX_W-1:0]  par_raddr;
    logic              par_we;
    logic [IDX_W-1:0]  par_waddr;
    logic [NODE_W-1:0] par_wdata;
    logic              mark_we;
    logic [IDX_W-1:0]  mark_waddr;
    logic [IDX_W-1:0]  mark_wdata;
    logic              inv_we;

    assign take           = (r_state == BK_IDLE) && !i_q_empty && !r_out_valid;
    assign o_valid        = r_out_valid;
    assign o_parent_index = r_out_parent;
    assign o_error        = r_out_err;
    assign par_raddr      = (r_state == BK_WREAD) ? r_i[IDX_W-1:0] : i_head.idx;
    assign inv_we         = take && (i_head.op == CMD_LOAD);

    // memories
    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_par_mem[par_waddr] <= par_wdata;
        end
        r_par_rdata <= r_par_mem[par_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_waddr] <= mark_wdata;
        end
        r_mark_rdata <= r_mark_mem[r_i[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (inv_we) begin
            r_inv_mem[i_head.row] <= i_head.idx;
        end
        r_inv_rdata <= r_inv_mem[i_head.row];
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_k        = r_k;
        n_steps    = r_steps;
        fin        = 1'b0;
        fin_parent = '0;
        fin_err    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (take) begin
                    case (i_head.op)
                        CMD_LOAD, CMD_START: begin
                            fin = 1'b1;
                        end
                        CMD_READ: begin
                            n_state = BK_RDATA;
                        end
                        CMD_ROW: begin
                            n_k     = i_head.col;
                            n_steps = '0;
                            if (i_cfg.use_perm) begin
                                n_state = BK_MAP;
                            end else if (i_head.row < i_head.col) begin
                                n_i     = {1'b0, i_head.row};
                                n_state = BK_WREAD;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            fin     = 1'b1;
                            fin_err = 1'b1;
                        end
                    endcase
                end
            end
            BK_MAP: begin
                if (r_inv_rdata < r_k) begin
                    n_i     = {1'b0, r_inv_rdata};
                    n_state = BK_WREAD;
                end else begin
                    fin = 1'b1;
                end
            end
            BK_WREAD: begin
                if (r_i >= NODE_W'(MAX_ORDER) || r_steps > NODE_W'(MAX_ORDER)) begin
                    fin = 1'b1;
                end else begin
                    n_state = BK_WCHK;
                end
            end
            BK_WCHK: begin
                if (r_mark_rdata == r_k) begin
                    fin = 1'b1;
                end else begin
                    n_i     = (r_par_rdata == i_cfg.n) ? {1'b0, r_k} : r_par_rdata;
                    n_steps = r_steps + NODE_W'(1);
                    n_state = BK_WREAD;
                end
            end
            BK_RDATA: begin
                fin        = 1'b1;
                fin_parent = r_par_rdata;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        n_out_valid  = r_out_valid && !i_pop;
        n_out_parent = r_out_parent;
        n_out_err    = r_out_err;
        if (fin) begin
            n_state      = BK_IDLE;
            n_out_valid  = 1'b1;
            n_out_parent = fin_parent;
            n_out_err    = fin_err;
        end
    end

    // memory and queue controls
    always_comb begin
        o_q_pop    = take;
        par_we     = 1'b0;
        par_waddr  = i_head.col;
        par_wdata  = i_cfg.n;
        mark_we    = 1'b0;
        mark_waddr = i_head.col;
        mark_wdata = i_head.col;
        case (r_state)
            BK_IDLE: begin
                if (take && i_head.op == CMD_START) begin
                    par_we  = 1'b1;
                    mark_we = 1'b1;
                end
            end
            BK_WCHK: begin
                mark_waddr = r_i[IDX_W-1:0];
                mark_wdata = r_k;
                par_waddr  = r_i[IDX_W-1:0];
                par_wdata  = {1'b0, r_k};
                if (r_mark_rdata != r_k) begin
                    mark_we = 1'b1;
                    par_we  = r_par_rdata == i_cfg.n;
                end
            end
            default: begin
                par_we  = 1'b0;
                mark_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_k          <= n_k;
        r_steps      <= n_steps;
        r_out_parent <= n_out_parent;
        r_out_err    <= n_out_err;
    end

    a_slot_free_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> !r_out_valid)
        else $error("result slot occupied while a command is in flight");

    a_error_parent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_parent == '0))
        else $error("error result carries a parent");

    a_walk_node_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_WCHK) |-> (r_i < NODE_W'(MAX_ORDER)))
        else $error("walk checks a node outside the store");

    a_pop_only_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_out_valid || r_state == BK_MAP || r_state == BK_WREAD
                     || r_state == BK_RDATA))
        else $error("command taken without progress");

endmodule
`default_nettype wire

// ===== rtl/symmetric_elimination_tree_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_elimination_tree_unit
// Elimination tree builder for a symmetric sparse matrix.
//
// Input queue: push/full with i_action, i_index, i_row. Output queue:
// empty/pop with o_parent_index, o_error; every transaction gives exactly
// one result, in order. Configuration: i_cfg_we writes register i_cfg_idx
// (0 matrix order, 1 permutation enable) in the same cycle; the user must
// write it only while idle, the block does not enforce it. The front end
// checks and classifies a transaction in its accept cycle and queues a
// command (4 deep). The back end runs one command at a time: rejected,
// load and start-column commands finish when taken, reads pass a read-data
// state, rows map via the inverse permutation if enabled, then walk the
// parent chain until a node marked for the column or the end of the store.
// A command starts only after the result register drains.
// One result register holds a finished result; while the receiver stalls
// the back end waits and the queue keeps taking commands until full.
// Reset empties the queue and result register, clears the current column
// and sets order 1024 with no permutation. Memory contents are undefined.
// ----------------------------------------------------------------------------
module symmetric_elimination_tree_unit import setu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [NODE_W-1:0] i_cfg_wdata,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [1:0]        i_action,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire logic [IDX_W-1:0]  i_row,
    output logic                   empty,
    input  wire logic              pop,
    output logic [NODE_W-1:0]      o_parent_index,
    output logic                   o_error
);

    logic [NODE_W-1:0] r_size;
    logic              r_use_perm;
    t_cfg              cfg;
    t_cmd              fe_cmd;
    logic              fe_push;
    t_cmd              q_head;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= NODE_W'(MAX_ORDER);
            r_use_perm <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE: r_size     <= i_cfg_wdata;
                CFG_PERM: r_use_perm <= i_cfg_wdata[0];
                default:  r_size     <= r_size;
            endcase
        end
    end

    always_comb begin
        if (r_size == '0) begin
            cfg.n = NODE_W'(1);
        end else if (r_size > NODE_W'(MAX_ORDER)) begin
            cfg.n = NODE_W'(MAX_ORDER);
        end else begin
            cfg.n = r_size;
        end
        cfg.use_perm = r_use_perm;
    end

    assign full  = q_full;
    assign empty = !out_valid;

    setu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .i_action   (i_action),
        .i_index    (i_index),
        .i_row      (i_row),
        .i_q_full   (q_full),
        .o_cmd      (fe_cmd),
        .o_cmd_push (fe_push)
    );

    setu_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_cmd   (fe_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    setu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_head         (q_head),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_valid        (out_valid),
        .o_parent_index (o_parent_index),
        .o_error        (o_error)
    );

endmodule
`default_nettype wire
